/* hw/rtl/ptd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg
// shared types and constants of the periodic task dispatcher
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned NumPrio    = 5;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_ENABLE  = 3'd2,
    OP_DISABLE = 3'd3,
    OP_TICK    = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SHIFT,
    S_OUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  task_id;
    logic [31:0] interval_ms;
    logic [2:0]  task_priority;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       due_valid;
    logic [7:0] due_id;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] interval;
    logic [31:0] last_run;
    logic [2:0]  prio;
    logic        enabled;
  } entry_t;

endpackage

/* hw/rtl/ptd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_req_if / ptd_rsp_if
// valid/ready channels carrying requests and results
// ----------------------------------------------------------------------------
interface ptd_req_if;
  logic          valid;
  logic          ready;
  ptd_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ptd_rsp_if;
  logic          valid;
  logic          ready;
  ptd_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/ptd_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_table
// task table memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ptd_table #(
  parameter int unsigned Depth = ptd_pkg::TableDepth,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  ptd_pkg::entry_t      wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output ptd_pkg::entry_t      rdata_o
);
  ptd_pkg::entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/ptd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_ctrl
// sequencer that scans, edits and dispatches from the task table
// ----------------------------------------------------------------------------
module ptd_ctrl #(
  parameter int unsigned Depth = ptd_pkg::TableDepth,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ptd_req_if.sink         req_i,
  ptd_rsp_if.source       rsp_o,
  output logic            we_o,
  output logic [AW-1:0]   waddr_o,
  output ptd_pkg::entry_t wdata_o,
  output logic [AW-1:0]   raddr_o,
  input  ptd_pkg::entry_t rdata_i
);
  ptd_pkg::state_e state_q, state_d;
  ptd_pkg::req_t   req_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [2:0]      prio_q, prio_d;
  logic            found_q, found_d;
  logic [AW-1:0]   fidx_q, fidx_d;
  ptd_pkg::rsp_t   out_q, out_d;
  logic            next_q, next_d;
  logic [CW-1:0]   idx_inc;
  logic            scan_end;
  logic            is_tick;
  logic            due;
  logic [31:0]     age;

  assign idx_inc  = idx_q + CW'(1);
  assign scan_end = (idx_inc >= count_q);
  assign is_tick  = (req_q.operation == ptd_pkg::OP_TICK);
  assign age      = req_q.now_ms - rdata_i.last_run;
  assign due      = rdata_i.enabled && (rdata_i.prio == prio_q) &&
                    ((rdata_i.last_run == '0) || (age >= rdata_i.interval));
  assign raddr_o  = idx_q[AW-1:0];

  assign req_i.ready   = (state_q == ptd_pkg::S_IDLE);
  assign rsp_o.valid   = (state_q == ptd_pkg::S_OUT);
  assign rsp_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptd_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.payload;
    end
    idx_q   <= idx_d;
    prio_q  <= prio_d;
    found_q <= found_d;
    fidx_q  <= fidx_d;
    out_q   <= out_d;
    next_q  <= next_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptd_pkg::S_IDLE: begin
        if (req_i.valid) begin
          state_d = ptd_pkg::S_READ;
        end
      end
      ptd_pkg::S_READ: begin
        if (idx_q >= count_q) begin
          if (is_tick && prio_q < 3'(ptd_pkg::NumPrio - 1)) begin
            state_d = ptd_pkg::S_READ;
          end else begin
            state_d = ptd_pkg::S_DONE;
          end
        end else begin
          state_d = ptd_pkg::S_EVAL;
        end
      end
      ptd_pkg::S_EVAL: begin
        if (is_tick && due) begin
          state_d = ptd_pkg::S_OUT;
        end else if (req_q.operation == ptd_pkg::OP_REMOVE && found_q) begin
          state_d = scan_end ? ptd_pkg::S_DONE : ptd_pkg::S_SHIFT;
        end else begin
          state_d = ptd_pkg::S_READ;
        end
      end
      ptd_pkg::S_SHIFT: state_d = ptd_pkg::S_READ;
      ptd_pkg::S_DONE:  state_d = ptd_pkg::S_OUT;
      ptd_pkg::S_OUT: begin
        if (rsp_o.ready) begin
          state_d = next_q ? ptd_pkg::S_READ : ptd_pkg::S_IDLE;
        end
      end
      default: state_d = ptd_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    prio_d  = prio_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    out_d   = out_q;
    next_d  = next_q;
    we_o    = 1'b0;
    waddr_o = fidx_q;
    wdata_o = rdata_i;
    case (state_q)
      ptd_pkg::S_IDLE: begin
        idx_d   = '0;
        prio_d  = '0;
        found_d = 1'b0;
        fidx_d  = '0;
      end
      ptd_pkg::S_READ: begin
        if (idx_q >= count_q && is_tick && prio_q < 3'(ptd_pkg::NumPrio - 1)) begin
          prio_d = prio_q + 3'd1;
          idx_d  = '0;
        end
      end
      ptd_pkg::S_EVAL: begin
        idx_d = idx_inc;
        if (is_tick) begin
          if (due) begin
            we_o             = 1'b1;
            waddr_o          = idx_q[AW-1:0];
            wdata_o.last_run = req_q.now_ms;
            out_d            = '{ptd_pkg::ST_OK, 1'b1, rdata_i.id, 1'b0};
            next_d           = 1'b1;
          end
        end else if (found_q) begin
          // remove: move this entry one place down
          we_o    = 1'b1;
          waddr_o = fidx_q;
          fidx_d  = idx_q[AW-1:0];
          if (scan_end) begin
            idx_d = count_q;
          end
        end else if (rdata_i.id == req_q.task_id) begin
          found_d = 1'b1;
          fidx_d  = idx_q[AW-1:0];
          if (req_q.operation == ptd_pkg::OP_ENABLE ||
              req_q.operation == ptd_pkg::OP_DISABLE) begin
            we_o            = 1'b1;
            waddr_o         = idx_q[AW-1:0];
            wdata_o.enabled = (req_q.operation == ptd_pkg::OP_ENABLE);
            idx_d           = count_q;
          end else if (req_q.operation == ptd_pkg::OP_ADD) begin
            idx_d = count_q;
          end else if (req_q.operation != ptd_pkg::OP_REMOVE) begin
            found_d = 1'b0;
          end else if (scan_end) begin
            idx_d = count_q;
          end
        end
      end
      ptd_pkg::S_DONE: begin
        out_d  = '{ptd_pkg::ST_OK, 1'b0, 8'd0, 1'b1};
        next_d = 1'b0;
        case (req_q.operation)
          ptd_pkg::OP_ADD: begin
            if (count_q >= CW'(Depth)) begin
              out_d.status = ptd_pkg::ST_FULL;
            end else if (found_q) begin
              out_d.status = ptd_pkg::ST_DUP;
            end else begin
              we_o    = 1'b1;
              waddr_o = count_q[AW-1:0];
              wdata_o = '{req_q.task_id, req_q.interval_ms, 32'd0,
                          req_q.task_priority, 1'b1};
              count_d = count_q + CW'(1);
            end
          end
          ptd_pkg::OP_REMOVE: begin
            if (found_q) begin
              count_d = count_q - CW'(1);
            end else begin
              out_d.status = ptd_pkg::ST_MISSING;
            end
          end
          ptd_pkg::OP_ENABLE, ptd_pkg::OP_DISABLE: begin
            if (!found_q) begin
              out_d.status = ptd_pkg::ST_MISSING;
            end
          end
          ptd_pkg::OP_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      ptd_pkg::S_OUT: begin
        // a dispatch result is final when nothing else is due afterwards;
        // hold it until the scan resumes and either finds more or ends
        if (rsp_o.ready && next_q) begin
          next_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/periodic_task_dispatcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// table of periodic tasks with add, remove, enable, disable, clear and tick
// ----------------------------------------------------------------------------
// req_i carries one request (operation, task_id, interval_ms, task_priority,
// now_ms); rsp_o returns results (status, due_valid, due_id, last).
// a table request gives one result with last set; a tick gives one result
// per dispatched task in priority order then table order, or one result with
// due_valid low when nothing is due.
// the table sits in a memory with one registered read port, so the scan reads
// each entry in a read state and checks it in the evaluate state that follows;
// an edit scans the table at most once, a tick once for each of the five priorities.
// one request is handled at a time; req ready is high only when idle.
// a dispatch result is held with last low; last is signalled by an extra
// look-ahead: the final dispatch is emitted only once the scan ends, so each
// held result waits on the scan.
// reset empties the table at once; no clearing pass is needed.
// a stalled receiver holds the result and pauses the scan.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher #(
  parameter int unsigned TableDepth = ptd_pkg::TableDepth
) (
  input logic        clk_i,
  input logic        rst_ni,
  ptd_req_if.sink    req_i,
  ptd_rsp_if.source  rsp_o
);
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  ptd_pkg::entry_t wdata;
  ptd_pkg::entry_t rdata;
  ptd_rsp_if       raw ();

  // one-deep hold stage so a dispatch is only shown once the next is known
  ptd_pkg::rsp_t   hold_q;
  logic            hold_v_q;

  ptd_table #(.Depth(TableDepth)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  ptd_ctrl #(.Depth(TableDepth)) u_ctrl (
    .clk_i, .rst_ni, .req_i(req_i), .rsp_o(raw.source),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  // a held dispatch is released when another result arrives; a final
  // no-dispatch marker after dispatches is dropped and sets last on the held one
  logic incoming_disp;
  logic release_now;
  assign incoming_disp = raw.valid && raw.payload.due_valid;
  assign release_now   = hold_v_q && raw.valid;

  always_comb begin
    rsp_o.valid   = release_now;
    rsp_o.payload = hold_q;
    raw.ready     = 1'b0;
    if (!hold_v_q) begin
      if (raw.valid && !raw.payload.due_valid) begin
        rsp_o.valid   = 1'b1;
        rsp_o.payload = raw.payload;
        raw.ready     = rsp_o.ready;
      end else begin
        raw.ready = 1'b1;
      end
    end else if (raw.valid) begin
      rsp_o.payload.last = !incoming_disp;
      raw.ready          = rsp_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else begin
      if (raw.valid && raw.ready) begin
        hold_v_q <= incoming_disp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw.valid && raw.ready && incoming_disp) begin
      hold_q <= raw.payload;
    end
  end

endmodule

/* hw/rtl/ptd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_checker
// port level checks of the periodic task dispatcher
// ----------------------------------------------------------------------------
module ptd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input ptd_pkg::rsp_t rsp_payload_i
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("result dropped while stalled");

  a_idle_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.due_valid |-> rsp_payload_i.due_id == 8'd0)
    else $error("id shown without dispatch");

  a_no_req_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.last |-> !req_ready_i)
    else $error("request taken inside a result burst");

  a_nondisp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.due_valid |-> rsp_payload_i.last)
    else $error("status result not final");
endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid), .rsp_ready_i(rsp_o.ready),
  .rsp_payload_i(rsp_o.payload)
);

/* tb/ptd_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_tb_if
// note: the channel interfaces come from the rtl (ptd_req_if, ptd_rsp_if);
// this file only holds the request item type used by the testbench driver
// ----------------------------------------------------------------------------
package ptd_tb_pkg;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  task_id;
    logic [31:0] interval_ms;
    logic [2:0]  task_priority;
    logic [31:0] now_ms;
    logic        hold_drain;
  } tb_req_t;

endpackage

/* tb/tb_periodic_task_dispatcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_dispatcher
// self-checking bench for the periodic task dispatcher: a queue-fed driver
// sends table edits and ticks, a predictor mirrors the task table and a
// monitor compares every result with the oldest expected one
// ----------------------------------------------------------------------------
module tb_periodic_task_dispatcher;
  import ptd_pkg::*;
  import ptd_tb_pkg::*;

  localparam int unsigned Depth = TableDepth;

  logic clk_i;
  logic rst_ni;

  ptd_req_if req_if ();
  ptd_rsp_if rsp_if ();

  periodic_task_dispatcher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predictor copy of the task table
  logic [7:0]  tbl_id       [Depth];
  logic [31:0] tbl_interval [Depth];
  logic [31:0] tbl_last_run [Depth];
  logic [2:0]  tbl_prio     [Depth];
  logic        tbl_enabled  [Depth];
  int unsigned tbl_count;

  tb_req_t pending_q[$];
  rsp_t    expected_q[$];

  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_dispatched;
  int unsigned n_requests;
  int unsigned stall_cycles;
  bit          stim_done;
  bit          req_taken;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int find_task(input logic [7:0] id);
    int idx;
    idx = -1;
    for (int i = 0; i < int'(tbl_count); i++) begin
      if (idx < 0 && tbl_id[i] == id) begin
        idx = i;
      end
    end
    return idx;
  endfunction

  function automatic rsp_t mk_rsp(input logic [1:0] st, input logic vld,
                                  input logic [7:0] id, input logic lst);
    rsp_t r;
    r.status    = st;
    r.due_valid = vld;
    r.due_id    = id;
    r.last      = lst;
    return r;
  endfunction

  // updates the table copy and queues the results of one request
  task automatic predict_dispatch(input tb_req_t rq);
    status_e st;
    int      idx;
    int      n;
    st = ST_OK;
    if (rq.operation == OP_TICK) begin
      n = 0;
      for (int p = 0; p < int'(NumPrio); p++) begin
        for (int i = 0; i < int'(tbl_count); i++) begin
          if (tbl_prio[i] == p && tbl_enabled[i] &&
              (tbl_last_run[i] == 32'd0 ||
               (rq.now_ms - tbl_last_run[i]) >= tbl_interval[i])) begin
            expected_q.push_back(mk_rsp(ST_OK, 1'b1, tbl_id[i], 1'b0));
            tbl_last_run[i] = rq.now_ms;
            n++;
          end
        end
      end
      if (n == 0) begin
        expected_q.push_back(mk_rsp(ST_OK, 1'b0, 8'd0, 1'b1));
      end else begin
        expected_q[$].last = 1'b1;
      end
      return;
    end
    case (rq.operation)
      OP_ADD: begin
        if (tbl_count >= Depth) begin
          st = ST_FULL;
        end else if (find_task(rq.task_id) >= 0) begin
          st = ST_DUP;
        end else begin
          tbl_id[tbl_count]       = rq.task_id;
          tbl_interval[tbl_count] = rq.interval_ms;
          tbl_last_run[tbl_count] = 32'd0;
          tbl_prio[tbl_count]     = rq.task_priority;
          tbl_enabled[tbl_count]  = 1'b1;
          tbl_count++;
        end
      end
      OP_REMOVE: begin
        idx = find_task(rq.task_id);
        if (idx < 0) begin
          st = ST_MISSING;
        end else begin
          for (int i = idx; i + 1 < int'(tbl_count); i++) begin
            tbl_id[i]       = tbl_id[i+1];
            tbl_interval[i] = tbl_interval[i+1];
            tbl_last_run[i] = tbl_last_run[i+1];
            tbl_prio[i]     = tbl_prio[i+1];
            tbl_enabled[i]  = tbl_enabled[i+1];
          end
          tbl_count--;
        end
      end
      OP_ENABLE, OP_DISABLE: begin
        idx = find_task(rq.task_id);
        if (idx < 0) begin
          st = ST_MISSING;
        end else begin
          tbl_enabled[idx] = (rq.operation == OP_ENABLE);
        end
      end
      OP_CLEAR: begin
        tbl_count = 0;
      end
      default: begin
      end
    endcase
    expected_q.push_back(mk_rsp(st, 1'b0, 8'd0, 1'b1));
  endtask

  function automatic tb_req_t mk_req(input logic [2:0] op, input logic [7:0] id,
                                     input logic [31:0] ivl, input logic [2:0] pr,
                                     input logic [31:0] now);
    tb_req_t r;
    r.operation     = op;
    r.task_id       = id;
    r.interval_ms   = ivl;
    r.task_priority = pr;
    r.now_ms        = now;
    r.hold_drain    = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] rand32();
    return $urandom;
  endfunction

  // driver
  int unsigned drv_gap;
  bit          drv_wait_drain;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      drv_gap        = 0;
      drv_wait_drain = 1'b0;
      req_taken      = 1'b0;
    end else if (req_if.valid && !req_taken) begin
      // hold current request
    end else if (drv_wait_drain && expected_q.size() != 0) begin
      req_if.valid <= 1'b0;
    end else if (drv_gap != 0) begin
      req_if.valid <= 1'b0;
      drv_gap--;
    end else if (pending_q.size() != 0) begin
      drv_wait_drain = pending_q[0].hold_drain;
      if (drv_wait_drain && expected_q.size() != 0) begin
        req_if.valid <= 1'b0;
      end else begin
        tb_req_t rq;
        rq = pending_q.pop_front();
        drv_wait_drain = 1'b0;
        req_taken      = 1'b0;
        req_if.valid                  <= 1'b1;
        req_if.payload.operation      <= rq.operation;
        req_if.payload.task_id        <= rq.task_id;
        req_if.payload.interval_ms    <= rq.interval_ms;
        req_if.payload.task_priority  <= rq.task_priority;
        req_if.payload.now_ms         <= rq.now_ms;
        drv_gap = ($urandom_range(2, 0) == 0) ? $urandom_range(4, 0) : 0;
      end
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // request accept: feed predictor
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      tb_req_t rq;
      rq = mk_req(req_if.payload.operation, req_if.payload.task_id,
                  req_if.payload.interval_ms, req_if.payload.task_priority,
                  req_if.payload.now_ms);
      predict_dispatch(rq);
      req_taken = 1'b1;
      n_requests++;
    end
  end

  // receiver ready with random stalls and one long hold-off
  int unsigned rdy_wait;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rdy_wait     = 0;
    end else if (stall_cycles != 0) begin
      rsp_if.ready <= 1'b0;
      stall_cycles--;
    end else if (rdy_wait != 0) begin
      rsp_if.ready <= 1'b0;
      rdy_wait--;
    end else begin
      rsp_if.ready <= 1'b1;
      if (rsp_if.valid && rsp_if.ready && $urandom_range(2, 0) == 0) begin
        rdy_wait = $urandom_range(4, 0);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_t got;
      rsp_t exp_r;
      got = rsp_if.payload;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d due_valid %0d due_id %0d last %0d",
               got.status, got.due_valid, got.due_id, got.last);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.due_valid) n_dispatched++;
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got.status);
          n_errors++;
        end
        if (got.due_valid !== exp_r.due_valid) begin
          $error("due_valid: expected %0d, got %0d", exp_r.due_valid, got.due_valid);
          n_errors++;
        end
        if (got.due_id !== exp_r.due_id) begin
          $error("due_id: expected %0d, got %0d", exp_r.due_id, got.due_id);
          n_errors++;
        end
        if (got.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, got.last);
          n_errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0]  ids [16];
    logic [31:0] now;
    tb_req_t     rq;
    int unsigned r;
    n_errors = 0; n_results = 0; n_dispatched = 0; n_requests = 0;
    stall_cycles = 0; stim_done = 1'b0; tbl_count = 0;
    req_if.valid = 1'b0; req_if.payload = '0; rsp_if.ready = 1'b0;
    rst_ni = 1'b0;

    // directed part
    pending_q.push_back(mk_req(OP_TICK, 8'h00, 32'd0, 3'd0, 32'd5));
    pending_q.push_back(mk_req(OP_REMOVE, 8'hFF, 32'd0, 3'd0, 32'd0));
    pending_q.push_back(mk_req(OP_ENABLE, 8'h12, 32'd0, 3'd0, 32'd0));
    pending_q.push_back(mk_req(OP_DISABLE, 8'h12, 32'd0, 3'd0, 32'd0));
    pending_q.push_back(mk_req(OP_ADD, 8'h00, 32'hFFFF_FFFF, 3'd4, 32'd0));
    pending_q.push_back(mk_req(OP_ADD, 8'hFF, 32'd0, 3'd0, 32'hFFFF_FFFF));
    pending_q.push_back(mk_req(OP_ADD, 8'hFF, 32'd3, 3'd1, 32'd0));
    pending_q.push_back(mk_req(OP_ADD, 8'h5A, 32'd10, 3'd7, 32'd0));
    pending_q.push_back(mk_req(OP_ADD, 8'hA5, 32'd10, 3'd2, 32'd0));
    pending_q.push_back(mk_req(OP_TICK, 8'h00, 32'd0, 3'd0, 32'd0));
    pending_q.push_back(mk_req(OP_TICK, 8'h00, 32'd0, 3'd0, 32'hFFFF_FFF8));
    pending_q.push_back(mk_req(OP_TICK, 8'h00, 32'd0, 3'd0, 32'd3));
    pending_q.push_back(mk_req(OP_DISABLE, 8'hA5, 32'd0, 3'd0, 32'd0));
    pending_q.push_back(mk_req(OP_TICK, 8'h00, 32'd0, 3'd0, 32'd100));
    pending_q.push_back(mk_req(OP_ENABLE, 8'hA5, 32'd0, 3'd0, 32'd0));
    pending_q.push_back(mk_req(OP_REMOVE, 8'h00, 32'd0, 3'd0, 32'd0));
    pending_q.push_back(mk_req(3'd6, 8'h00, 32'd0, 3'd0, 32'd0));
    pending_q.push_back(mk_req(3'd7, 8'hFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF));
    pending_q.push_back(mk_req(OP_CLEAR, 8'h00, 32'd0, 3'd0, 32'd0));
    for (int i = 0; i < 17; i++) begin
      pending_q.push_back(mk_req(OP_ADD, 8'(i * 13 + 1), 32'(i), 3'(i % 5), 32'd0));
    end
    pending_q.push_back(mk_req(OP_TICK, 8'h00, 32'd0, 3'd0, 32'd1000));
    rq = mk_req(OP_TICK, 8'h00, 32'd0, 3'd0, 32'd2000);
    rq.hold_drain = 1'b1;
    pending_q.push_back(rq);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // long receiver stall while requests keep coming
    repeat (40) @(posedge clk_i);
    stall_cycles = 300;

    // random part: sessions of adds then ticks with random edits
    now = rand32();
    for (int k = 0; k < 12; k++) begin
      rq = mk_req(OP_CLEAR, 8'h00, 32'd0, 3'd0, 32'd0);
      rq.hold_drain = (k == 6);
      pending_q.push_back(rq);
      for (int i = 0; i < 16; i++) ids[i] = 8'($urandom);
      r = $urandom_range(16, 1);
      for (int i = 0; i < int'(r); i++) begin
        pending_q.push_back(mk_req(OP_ADD, ids[$urandom_range(15, 0)],
                                   ($urandom_range(3, 0) == 0) ? rand32()
                                                               : $urandom_range(40, 0),
                                   3'($urandom_range(7, 0)), rand32()));
      end
      for (int i = 0; i < 15; i++) begin
        now = now + $urandom_range(30, 0);
        case ($urandom_range(9, 0))
          0: pending_q.push_back(mk_req(OP_REMOVE, ids[$urandom_range(15, 0)],
                                        rand32(), 3'($urandom), rand32()));
          1: pending_q.push_back(mk_req(OP_ENABLE, ids[$urandom_range(15, 0)],
                                        rand32(), 3'($urandom), rand32()));
          2: pending_q.push_back(mk_req(OP_DISABLE, ids[$urandom_range(15, 0)],
                                        rand32(), 3'($urandom), rand32()));
          3: pending_q.push_back(mk_req(OP_ADD, 8'($urandom), rand32(),
                                        3'($urandom), rand32()));
          4: pending_q.push_back(mk_req(3'($urandom), 8'($urandom), rand32(),
                                        3'($urandom), rand32()));
          default: pending_q.push_back(mk_req(OP_TICK, 8'($urandom), rand32(),
                                              3'($urandom), now));
        endcase
      end
    end
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (rst_ni && pending_q.size() == 0 && expected_q.size() == 0 &&
          !req_if.valid);
    repeat (200) @(posedge clk_i);
    $display("ran %0d requests, checked %0d results, %0d task dispatches",
             n_requests, n_results, n_dispatched);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("** periodic_task_dispatcher: PASSED **");
    end else begin
      $display("** periodic_task_dispatcher: FAILED **");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("** periodic_task_dispatcher: FAILED **");
    $finish;
  end

endmodule
